// ----- hdl/ctd_pkg.sv -----
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types and constants for the certificate table deframer.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REV_W     = 16;
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned HCNT_W    = $clog2(HDR_BYTES);
  localparam int unsigned PAD_W     = $clog2(HDR_BYTES);

  localparam logic [REV_W-1:0] REV_2_0 = 16'h0200;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD
  } phase_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              cert_first;
    logic              cert_last;
    logic [WORD_W-1:0] cert_length;
    logic              table_done;
    logic              format_error;
  } result_t;

  typedef struct packed {
    logic ended;
    logic error;
  } parse_status_t;

endpackage

// ----- hdl/ctd_if.sv -----
// ----------------------------------------------------------------------------
// ctd_if
// Valid/ready channels for table bytes in and deframed results out.
// ----------------------------------------------------------------------------
interface ctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ctd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        cert_first;
  logic        cert_last;
  logic [31:0] cert_length;
  logic        table_done;
  logic        format_error;

  modport source (
    output valid, output payload_valid, output payload_byte, output cert_first,
    output cert_last, output cert_length, output table_done, output format_error,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input cert_first,
    input cert_last, input cert_length, input table_done, input format_error,
    output ready
  );
endinterface

// ----- hdl/ctd_parser.sv -----
// ----------------------------------------------------------------------------
// ctd_parser
// Parse state and combinational step logic: header gather, payload, padding.
// ----------------------------------------------------------------------------
module ctd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [7:0]                    data_byte,
  input  logic [31:0]                   table_size,
  output ctd_pkg::result_t              result,
  output ctd_pkg::parse_status_t        status
);
  import ctd_pkg::*;

  logic [WORD_W-1:0] byte_offset, byte_offset_next;
  phase_t            phase, phase_next;
  logic [WORD_W-1:0] hdr_len, hdr_len_next;
  logic [REV_W-1:0]  hdr_rev, hdr_rev_next;
  logic [HCNT_W-1:0] header_count, header_count_next;
  logic [WORD_W-1:0] bytes_left, bytes_left_next;
  logic [WORD_W-1:0] cert_len, cert_len_next;
  logic              entry_accepted, entry_accepted_next;
  logic              ended_flag, ended_flag_next;
  logic              error_flag, error_flag_next;

  logic              off_max;
  logic [WORD_W-1:0] off_inc;
  logic [WORD_W-1:0] left_after;
  logic [PAD_W-1:0]  pad;
  logic [WORD_W-1:0] plen;

  assign off_max    = &byte_offset;
  assign off_inc    = byte_offset + WORD_W'(1);
  assign left_after = (bytes_left != '0) ? bytes_left - WORD_W'(1) : '0;
  // padding to the next 8-byte boundary after this byte: -(offset + 1) mod 8
  assign pad        = ~byte_offset[PAD_W-1:0];
  assign plen       = hdr_len - WORD_W'(HDR_BYTES);

  always_comb begin
    byte_offset_next    = byte_offset;
    phase_next          = phase;
    hdr_len_next        = hdr_len;
    hdr_rev_next        = hdr_rev;
    header_count_next   = header_count;
    bytes_left_next     = bytes_left;
    cert_len_next       = cert_len;
    entry_accepted_next = entry_accepted;
    ended_flag_next     = ended_flag;
    error_flag_next     = error_flag;
    result              = '0;

    if (!ended_flag) begin
      priority if (phase == PH_PAYLOAD) begin
        if (entry_accepted && bytes_left != '0) begin
          result.payload_valid = 1'b1;
          result.payload_byte  = data_byte;
          result.cert_first    = (bytes_left == cert_len);
          result.cert_last     = (bytes_left == WORD_W'(1));
          result.cert_length   = cert_len;
        end
        bytes_left_next = left_after;
        if (off_max) ended_flag_next = 1'b1;
        else byte_offset_next = off_inc;
        if (left_after == '0 && !off_max) begin
          if (pad != '0) begin
            phase_next      = PH_PAD;
            bytes_left_next = WORD_W'(pad);
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end else if (phase == PH_PAD) begin
        bytes_left_next = left_after;
        if (off_max) ended_flag_next = 1'b1;
        else byte_offset_next = off_inc;
        if (left_after == '0) phase_next = PH_HEADER;
      end else begin
        // header phase; the unused phase code lands here as well
        phase_next = PH_HEADER;
        if (header_count == '0 &&
            ({1'b0, byte_offset} + (WORD_W+1)'(HDR_BYTES) >= {1'b0, table_size})) begin
          ended_flag_next = 1'b1;
        end else begin
          if (!header_count[HCNT_W-1]) begin
            hdr_len_next[{header_count[1:0], 3'b000} +: BYTE_W] = data_byte;
          end else if (header_count[1] == 1'b0) begin
            hdr_rev_next[{header_count[0], 3'b000} +: BYTE_W] = data_byte;
          end
          header_count_next = header_count + HCNT_W'(1);
          if (off_max) ended_flag_next = 1'b1;
          else byte_offset_next = off_inc;
          // length is complete by the last header beat
          if (header_count == HCNT_W'(HDR_BYTES - 1) && !off_max) begin
            if (hdr_len < WORD_W'(HDR_BYTES)) begin
              error_flag_next = 1'b1;
              ended_flag_next = 1'b1;
            end else if ({2'b00, off_inc} + {2'b00, plen} > {2'b00, table_size}) begin
              ended_flag_next = 1'b1;
            end else if (plen != '0) begin
              phase_next          = PH_PAYLOAD;
              bytes_left_next     = plen;
              cert_len_next       = plen;
              entry_accepted_next = (hdr_rev == REV_2_0);
            end
          end
        end
      end
    end

    result.table_done   = ended_flag_next;
    result.format_error = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      phase          <= PH_HEADER;
      hdr_len        <= '0;
      hdr_rev        <= '0;
      header_count   <= '0;
      bytes_left     <= '0;
      cert_len       <= '0;
      entry_accepted <= 1'b0;
      ended_flag     <= 1'b0;
      error_flag     <= 1'b0;
    end else if (step) begin
      byte_offset    <= byte_offset_next;
      phase          <= phase_next;
      hdr_len        <= hdr_len_next;
      hdr_rev        <= hdr_rev_next;
      header_count   <= header_count_next;
      bytes_left     <= bytes_left_next;
      cert_len       <= cert_len_next;
      entry_accepted <= entry_accepted_next;
      ended_flag     <= ended_flag_next;
      error_flag     <= error_flag_next;
    end
  end

  assign status.ended = ended_flag;
  assign status.error = error_flag;

endmodule

// ----- hdl/ctd_out_reg.sv -----
// ----------------------------------------------------------------------------
// ctd_out_reg
// Result register with valid/ready hold toward the receiver.
// ----------------------------------------------------------------------------
module ctd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ctd_pkg::result_t  d,
  input  logic              ready,
  output logic              valid,
  output ctd_pkg::result_t  q
);
  import ctd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// ----- hdl/cert_table_deframer_core.sv -----
// ----------------------------------------------------------------------------
// cert_table_deframer_core
// Walks a certificate table one byte per beat and passes out payload bytes.
// ----------------------------------------------------------------------------
// Usage: set table_size through cfg_wr_en/cfg_wr_data while idle, then stream
// the table on in_ch, one byte per beat. Every input beat yields exactly one
// beat on out_ch carrying payload_valid/payload_byte with first/last marks,
// the certificate payload length, and the table_done and format_error flags.
// Bytes after table end still yield a beat, with the payload fields idle.
// Path: a byte accepted on in_ch passes the input register, then the result
// register, on its way to out_ch.
// Throughput: one byte per cycle while out_ch.ready is high; each byte is a
// single pass of compare, add and shift logic between the two registers.
// Stall: the result register holds while out_ch.ready is low, and the input
// register still takes one more byte; in_ch.ready drops only when both hold.
// Reset: rst is synchronous; it clears the parse state, the flags,
// table_size and the valid flags of both registers; their data is not reset.
// ----------------------------------------------------------------------------
module cert_table_deframer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  ctd_in_if.sink           in_ch,
  ctd_out_if.source        out_ch
);
  import ctd_pkg::*;

  logic [WORD_W-1:0] table_size;
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              step;
  logic              out_valid;
  result_t           step_result;
  result_t           out_q;
  parse_status_t     status;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  assign step        = in_full && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.data_byte;
    end
  end

  ctd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .table_size (table_size),
    .result     (step_result),
    .status     (status)
  );

  ctd_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (step),
    .d     (step_result),
    .ready (out_ch.ready),
    .valid (out_valid),
    .q     (out_q)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.payload_valid = out_q.payload_valid;
  assign out_ch.payload_byte  = out_q.payload_byte;
  assign out_ch.cert_first    = out_q.cert_first;
  assign out_ch.cert_last     = out_q.cert_last;
  assign out_ch.cert_length   = out_q.cert_length;
  assign out_ch.table_done    = out_q.table_done;
  assign out_ch.format_error  = out_q.format_error;

  // a format error always ends the table
  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    status.error |-> status.ended)
    else $error("format error without table end");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    status.error |=> status.error)
    else $error("format error flag cleared");

  a_single_byte_cert: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.cert_first && out_ch.cert_last) |->
      (out_ch.cert_length == 32'd1))
    else $error("first and last on one beat with length other than one");

  a_marks_need_payload: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.payload_valid) |->
      (!out_ch.cert_first && !out_ch.cert_last && out_ch.cert_length == 32'd0))
    else $error("certificate marks on a non-payload beat");

endmodule

// ----- bench/cert_table_deframer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cert_table_deframer_core_tb
// Streams certificate tables, well-formed entries with random content plus
// skipped and empty entries, into the deframer, with random idling on both
// sides in the first two runs. A local model of the parser predicts every
// output beat, and the monitor compares each one field by field. The run
// closes with one table-end case chosen at random, then bytes past the end.
// ----------------------------------------------------------------------------
module cert_table_deframer_core_tb;
  import ctd_pkg::*;

  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned MAX_PRINTED  = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  ctd_in_if  in_ch ();
  ctd_out_if out_ch ();

  cert_table_deframer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Table bytes waiting to be sent and predicted output beats.
  logic [7:0]  table_bytes[$];
  result_t     expected_beats[$];

  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned bytes_in = 0;
  int unsigned beats_out = 0;
  int unsigned fault_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic [31:0] gen_offset = '0;

  // Parser model state.
  logic [31:0] tbl_size;
  logic [31:0] cur_offset;
  phase_t      cur_phase;
  logic [63:0] hdr_shift;
  logic [3:0]  hdr_count;
  logic [31:0] left_count;
  logic        entry_ok;
  logic        table_ended;
  logic        fmt_err;

  function automatic void step_offset();
    if (cur_offset == 32'hFFFF_FFFF) table_ended = 1'b1;
    else cur_offset = cur_offset + 32'd1;
  endfunction

  function automatic result_t deframe_step(input logic [7:0] b);
    result_t     r;
    logic [31:0] plen;
    logic [2:0]  pad;
    r = '0;
    if (!table_ended) begin
      case (cur_phase)
        PH_PAYLOAD: begin
          plen = hdr_shift[31:0] - HDR_BYTES;
          if (entry_ok && left_count != 0) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.cert_first    = (left_count == plen);
            r.cert_last     = (left_count == 32'd1);
            r.cert_length   = plen;
          end
          if (left_count != 0) left_count = left_count - 32'd1;
          step_offset();
          if (left_count == 0 && !table_ended) begin
            pad = 3'd0 - cur_offset[2:0];
            if (pad != 0) begin
              cur_phase  = PH_PAD;
              left_count = 32'(pad);
            end else begin
              cur_phase = PH_HEADER;
            end
          end
        end
        PH_PAD: begin
          if (left_count != 0) left_count = left_count - 32'd1;
          step_offset();
          if (left_count == 0) cur_phase = PH_HEADER;
        end
        default: begin
          cur_phase = PH_HEADER;
          if (hdr_count == 0 && ({1'b0, cur_offset} + 33'd8) >= {1'b0, tbl_size}) begin
            table_ended = 1'b1;
          end else begin
            if (hdr_count == 0) hdr_shift = '0;
            hdr_shift = hdr_shift | (64'(b) << (8 * hdr_count[2:0]));
            hdr_count = hdr_count + 4'd1;
            step_offset();
            if (hdr_count >= HDR_BYTES && !table_ended) begin
              hdr_count = '0;
              if (hdr_shift[31:0] < HDR_BYTES) begin
                fmt_err     = 1'b1;
                table_ended = 1'b1;
              end else begin
                plen = hdr_shift[31:0] - HDR_BYTES;
                if (({1'b0, cur_offset} + {1'b0, plen}) > {1'b0, tbl_size}) begin
                  table_ended = 1'b1;
                end else if (plen != 0) begin
                  cur_phase  = PH_PAYLOAD;
                  left_count = plen;
                  entry_ok   = (hdr_shift[47:32] == REV_2_0);
                end
              end
            end
          end
        end
      endcase
    end
    r.table_done   = table_ended;
    r.format_error = fmt_err;
    return r;
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_PRINTED) $display("ERROR out beat %0d: %s", beats_out, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_fault($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Input driver: offers the head of the byte queue, holds it until taken.
  always @(posedge clk) begin : driver
    logic took;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        expected_beats.push_back(deframe_step(in_ch.data_byte));
        void'(table_bytes.pop_front());
        bytes_in++;
      end
      if (in_ch.valid && !took) begin
        // hold the beat
      end else if (table_bytes.size() != 0 && $urandom_range(99) >= snd_idle) begin
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= table_bytes[0];
      end else begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'($urandom);
      end
    end
  end

  // Long receiver hold-off so the input side backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          report_fault("output beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          check_field("payload_valid", 32'(out_ch.payload_valid), 32'(want.payload_valid));
          check_field("payload_byte", 32'(out_ch.payload_byte), 32'(want.payload_byte));
          check_field("cert_first", 32'(out_ch.cert_first), 32'(want.cert_first));
          check_field("cert_last", 32'(out_ch.cert_last), 32'(want.cert_last));
          check_field("cert_length", out_ch.cert_length, want.cert_length);
          check_field("table_done", 32'(out_ch.table_done), 32'(want.table_done));
          check_field("format_error", 32'(out_ch.format_error), 32'(want.format_error));
        end
        beats_out++;
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no beat for %0d cycles, %0d results pending", stall_cycles,
                 expected_beats.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_table_size(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    tbl_size = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (table_bytes.size() != 0 || expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One entry: header with the given length field, then body and pad bytes.
  task automatic push_entry(input logic [31:0] hlen, input logic [15:0] rev,
                            input int unsigned body, input int fill = -1);
    logic [63:0] hdr;
    int unsigned pad;
    hdr = {16'($urandom), rev, hlen};
    for (int i = 0; i < 8; i++) table_bytes.push_back(hdr[8*i +: 8]);
    for (int unsigned i = 0; i < body; i++)
      table_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    pad = (8 - (body % 8)) % 8;
    for (int unsigned i = 0; i < pad; i++)
      table_bytes.push_back((fill < 0) ? 8'($urandom) : 8'h00);
    gen_offset = gen_offset + 32'(8 + body + pad);
  endtask

  task automatic gen_entries(input int unsigned nbytes);
    logic [31:0] stop;
    int unsigned pick;
    int unsigned plen;
    logic [15:0] rev;
    stop = gen_offset + nbytes;
    while (gen_offset < stop) begin
      pick = $urandom_range(99);
      if (pick < 8) plen = $urandom_range(64, 160);
      else if (pick < 20) plen = 0;
      else plen = $urandom_range(1, 20);
      rev = ($urandom_range(99) < 70) ? REV_2_0 : 16'($urandom);
      push_entry(32'(plen) + HDR_BYTES, rev, plen);
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    tbl_size    = '0;
    cur_offset  = '0;
    cur_phase   = PH_HEADER;
    hdr_shift   = '0;
    hdr_count   = '0;
    left_count  = '0;
    entry_ok    = 1'b0;
    table_ended = 1'b0;
    fmt_err     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    snd_idle = 36;
    rcv_idle = 46;
    write_table_size(32'hFFFF_FFFF);
    // one-byte certificate of all ones with zero padding, then an empty
    // entry with a foreign revision
    push_entry(32'd9, REV_2_0, 1, 8'hFF);
    push_entry(32'd8, 16'hFFFF, 0);
    gen_entries(700);
    drain();

    snd_idle = 46;
    rcv_idle = 36;
    write_table_size(gen_offset + 32'($urandom_range(5000, 100000)));
    gen_entries(700);
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    write_table_size({1'b1, 31'($urandom)});
    gen_entries(500);
    drain();

    // close the table one way or another
    case ($urandom_range(4))
      0: begin
        write_table_size(gen_offset + 32'($urandom_range(0, 8)));
        for (int i = 0; i < 12; i++) table_bytes.push_back(8'($urandom));
      end
      1: push_entry(32'($urandom_range(0, 7)), REV_2_0, 8);
      2: begin
        p = $urandom_range(0, 20);
        write_table_size(gen_offset + 32'(9 + p));
        push_entry(32'(p + 2) + HDR_BYTES, REV_2_0, p + 2);
      end
      3: begin
        // pad bytes run past the table size, next header check ends it
        write_table_size(gen_offset + 32'(9 + $urandom_range(0, 5)));
        push_entry(32'd9, REV_2_0, 1);
        push_entry(32'd12, REV_2_0, 4);
      end
      default: begin
        write_table_size('0);
        for (int i = 0; i < 10; i++) table_bytes.push_back(8'($urandom));
      end
    endcase
    drain();

    // bytes after the end are ignored whatever the size
    write_table_size('0);
    for (int i = 0; i < 10; i++) table_bytes.push_back(8'($urandom));
    drain();

    repeat (8) @(posedge clk);
    if (fault_count == 0 && expected_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
